[hw/rtl/tgad_pkg.sv]
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and constants for the TGA image stream decoder: request
// structs for both channels, the parse phase encoding and header offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgad_pkg;

  // one file byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } tgad_in_t;

  // one decoded pixel (or run of pixels) or an error report
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       status;
  } tgad_out_t;

  // parse phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd2,
    PH_IDLE   = 2'd3
  } tgad_phase_t;

  // header byte offsets
  localparam logic [8:0] HDR_ID_LEN    = 9'd0;
  localparam logic [8:0] HDR_KIND      = 9'd2;
  localparam logic [8:0] HDR_WIDTH_LO  = 9'd12;
  localparam logic [8:0] HDR_WIDTH_HI  = 9'd13;
  localparam logic [8:0] HDR_HEIGHT_LO = 9'd14;
  localparam logic [8:0] HDR_HEIGHT_HI = 9'd15;
  localparam logic [8:0] HDR_DEPTH     = 9'd16;
  localparam logic [8:0] HDR_LEN       = 9'd17;

  // image type and pixel depths
  localparam logic [7:0] KIND_RLE_TRUE = 8'd10;
  localparam logic [7:0] DEPTH_16      = 8'd16;
  localparam logic [7:0] DEPTH_24      = 8'd24;
  localparam logic [7:0] DEPTH_32      = 8'd32;

  // status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_DEPTH = 1'b1;

endpackage

[hw/rtl/tga_image_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// Byte-serial TGA decoder: header parse, ID skip, raw and RLE pixel decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The decoder takes one file byte per clock unless a stalled result holds it,
// and gives at most one request per byte on the pixel side: one result per
// pixel for uncompressed images, one per raw pixel or one per run (with a
// repeat count) for type 10 images, and a single error request with status
// set when the pixel depth is unsupported. Throughput is one byte per cycle
// while no stalled result blocks it. Each byte sits in the input register
// while the decode logic feeds the result register, which offers its result.
// The widest path is the 16x16 width-times-height multiply at the end of the
// header, which loads the remaining pixel count directly. There is no clearing
// pass after reset. Assert file_start on the first byte of each file; after the
// image ends the block ignores bytes until the next file_start.
module tga_image_stream_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  tgad_pkg::tgad_in_t byte_item,
  output logic               pix_valid,
  input  logic               pix_stall,
  output tgad_pkg::tgad_out_t pix_item
);

  // input register
  logic               in_full;
  tgad_pkg::tgad_in_t in_q;
  logic               advance;

  // decoder state
  tgad_pkg::tgad_phase_t phase, phase_next;
  logic [8:0]  hpos, hpos_next;
  logic [7:0]  id_field_length, id_field_length_next;
  logic [7:0]  image_kind, image_kind_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [7:0]  pixel_depth, pixel_depth_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [23:0] pixel_bytes, pixel_bytes_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;

  // decode signals
  tgad_pkg::tgad_phase_t cur_phase;
  logic [8:0]  cur_hpos;
  logic [31:0] area;
  logic        is_rle;
  logic        depth_ok;
  logic [2:0]  bpp;
  logic [7:0]  count;
  logic [15:0] word16;
  tgad_pkg::tgad_out_t res;
  logic        res_valid;

  // output register
  logic                out_full;
  tgad_pkg::tgad_out_t out_q;

  assign advance    = in_full && (!out_full || !pix_stall);
  assign byte_stall = in_full && !advance;
  assign pix_valid  = out_full;
  assign pix_item   = out_q;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
    if (!byte_stall && byte_valid) begin
      in_q <= byte_item;
    end
  end

  // image size product and depth check
  assign area   = {16'd0, image_width} * {16'd0, image_height};
  assign is_rle = (image_kind == tgad_pkg::KIND_RLE_TRUE);
  assign depth_ok = (pixel_depth == tgad_pkg::DEPTH_24) || (pixel_depth == tgad_pkg::DEPTH_32) ||
                    (!is_rle && (pixel_depth == tgad_pkg::DEPTH_16));
  assign bpp = (pixel_depth == tgad_pkg::DEPTH_16) ? 3'd2 :
               (pixel_depth == tgad_pkg::DEPTH_24) ? 3'd3 : 3'd4;

  // restart view of phase and header position
  assign cur_phase = in_q.file_start ? tgad_pkg::PH_HEADER : phase;
  assign cur_hpos  = in_q.file_start ? 9'd0 : hpos;

  // next state and result
  always_comb begin
    phase_next           = phase;
    hpos_next            = hpos;
    id_field_length_next = id_field_length;
    image_kind_next      = image_kind;
    image_width_next     = image_width;
    image_height_next    = image_height;
    pixel_depth_next     = pixel_depth;
    pixels_left_next     = pixels_left;
    pixel_bytes_next     = pixel_bytes;
    byte_in_pixel_next   = byte_in_pixel;
    packet_left_next     = packet_left;
    packet_is_run_next   = packet_is_run;
    res                  = '0;
    res_valid            = 1'b0;
    count                = 8'd1;
    word16               = {in_q.data_byte, pixel_bytes[7:0]};

    if (advance) begin
      // new file abandons the current image
      if (in_q.file_start) begin
        phase_next         = tgad_pkg::PH_HEADER;
        hpos_next          = '0;
        pixels_left_next   = '0;
        packet_left_next   = '0;
        packet_is_run_next = 1'b0;
        pixel_bytes_next   = '0;
        byte_in_pixel_next = '0;
      end

      unique case (cur_phase)
        tgad_pkg::PH_HEADER: begin
          case (cur_hpos)
            tgad_pkg::HDR_ID_LEN:    id_field_length_next = in_q.data_byte;
            tgad_pkg::HDR_KIND:      image_kind_next = in_q.data_byte;
            tgad_pkg::HDR_WIDTH_LO:  image_width_next[7:0] = in_q.data_byte;
            tgad_pkg::HDR_WIDTH_HI:  image_width_next[15:8] = in_q.data_byte;
            tgad_pkg::HDR_HEIGHT_LO: image_height_next[7:0] = in_q.data_byte;
            tgad_pkg::HDR_HEIGHT_HI: image_height_next[15:8] = in_q.data_byte;
            tgad_pkg::HDR_DEPTH:     pixel_depth_next = in_q.data_byte;
            default: ;
          endcase
          hpos_next = cur_hpos + 9'd1;
          // last byte of the header and ID field: start the image or report a bad depth
          if (cur_hpos >= tgad_pkg::HDR_LEN &&
              cur_hpos == tgad_pkg::HDR_LEN + {1'b0, id_field_length}) begin
            if (!depth_ok) begin
              res.image_done = 1'b1;
              res.status     = tgad_pkg::STATUS_BAD_DEPTH;
              res_valid      = 1'b1;
              phase_next     = tgad_pkg::PH_IDLE;
            end else begin
              pixels_left_next   = area;
              pixel_bytes_next   = '0;
              byte_in_pixel_next = '0;
              packet_left_next   = '0;
              packet_is_run_next = 1'b0;
              phase_next = (image_width == 16'd0 || image_height == 16'd0) ?
                           tgad_pkg::PH_IDLE : tgad_pkg::PH_PIXELS;
            end
          end
        end

        tgad_pkg::PH_PIXELS: begin
          if (is_rle && packet_left == 8'd0) begin
            // packet header
            if (!in_q.data_byte[7]) begin
              count              = in_q.data_byte + 8'd1;
              packet_is_run_next = 1'b0;
            end else begin
              count              = in_q.data_byte - 8'd127;
              packet_is_run_next = 1'b1;
            end
            if ({24'd0, count} > pixels_left) begin
              count = pixels_left[7:0];
            end
            packet_left_next = count;
          end else if ({1'b0, byte_in_pixel} + 3'd1 < bpp) begin
            // gather a pixel byte
            case (byte_in_pixel)
              2'd0:    pixel_bytes_next[7:0]   = pixel_bytes[7:0] | in_q.data_byte;
              2'd1:    pixel_bytes_next[15:8]  = pixel_bytes[15:8] | in_q.data_byte;
              default: pixel_bytes_next[23:16] = pixel_bytes[23:16] | in_q.data_byte;
            endcase
            byte_in_pixel_next = byte_in_pixel + 2'd1;
          end else begin
            // last byte of the pixel: convert to rgb(a)
            if (bpp == 3'd2) begin
              res.blue  = {word16[4:0], 3'b000};
              res.green = {word16[9:5], 3'b000};
              res.red   = {word16[14:10], 3'b000};
            end else if (bpp == 3'd3) begin
              res.blue  = pixel_bytes[7:0];
              res.green = pixel_bytes[15:8];
              res.red   = in_q.data_byte;
            end else begin
              res.blue  = pixel_bytes[7:0];
              res.green = pixel_bytes[15:8];
              res.red   = pixel_bytes[23:16];
              res.alpha = in_q.data_byte;
            end
            pixel_bytes_next   = '0;
            byte_in_pixel_next = '0;
            // repeat count for runs, countdown of raw packet pixels
            if (is_rle) begin
              if (packet_is_run) begin
                count            = packet_left;
                packet_left_next = '0;
              end else begin
                packet_left_next = packet_left - 8'd1;
              end
            end
            if ({24'd0, count} > pixels_left) begin
              count = pixels_left[7:0];
            end
            pixels_left_next = pixels_left - {24'd0, count};
            res.has_alpha    = (pixel_depth == tgad_pkg::DEPTH_32);
            res.repeat_count = count;
            res.image_done   = (pixels_left_next == 32'd0);
            res.status       = tgad_pkg::STATUS_OK;
            res_valid        = 1'b1;
            if (pixels_left_next == 32'd0) begin
              phase_next = tgad_pkg::PH_IDLE;
            end
          end
        end

        default: ;
      endcase
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tgad_pkg::PH_HEADER;
      hpos            <= '0;
      id_field_length <= '0;
      image_kind      <= '0;
      image_width     <= '0;
      image_height    <= '0;
      pixel_depth     <= '0;
      pixels_left     <= '0;
      pixel_bytes     <= '0;
      byte_in_pixel   <= '0;
      packet_left     <= '0;
      packet_is_run   <= 1'b0;
    end else begin
      phase           <= phase_next;
      hpos            <= hpos_next;
      id_field_length <= id_field_length_next;
      image_kind      <= image_kind_next;
      image_width     <= image_width_next;
      image_height    <= image_height_next;
      pixel_depth     <= pixel_depth_next;
      pixels_left     <= pixels_left_next;
      pixel_bytes     <= pixel_bytes_next;
      byte_in_pixel   <= byte_in_pixel_next;
      packet_left     <= packet_left_next;
      packet_is_run   <= packet_is_run_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid) begin
      out_full <= 1'b1;
    end else if (!pix_stall) begin
      out_full <= 1'b0;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // an error request always closes the image
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_item.status |-> pix_item.image_done)
    else $error("error request without image_done");

  // a pixel request covers at least one pixel
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_item.status |-> pix_item.repeat_count != 8'd0)
    else $error("pixel request with zero repeat count");

  // the byte side stalls only while a byte waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> in_full && pix_valid && pix_stall)
    else $error("byte stall without a stalled result");

  // after the closing request, no new pixel work until a new file
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.image_done |=> phase == tgad_pkg::PH_IDLE)
    else $error("decoder not idle after image end");
`endif

endmodule

[dv/tga_image_stream_decoder_test.sv]
// ----------------------------------------------------------------------------
// tga_image_stream_decoder_test
// Byte-level test of the TGA decoder. Whole files are streamed in: headers,
// ID fields, raw 16/24/32-bit pixels and type 10 run-length packets, plus
// bad depths, empty images, restarts and stray bytes. A software copy of the
// decoder predicts every pixel request, and each one that comes out is
// compared field by field. Both sides idle at random; the receiver also holds
// off for a long stretch so the decoder backs up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_image_stream_decoder_test;

  // image types used by the stimulus (type 10 comes from the package)
  localparam logic [7:0] KIND_NONE      = 8'd0;
  localparam logic [7:0] KIND_RAW_TRUE  = 8'd2;
  localparam logic [7:0] KIND_RAW_GRAY  = 8'd3;
  localparam int         HOLD_CYCLES    = 200;
  localparam int         QUIET_LIMIT    = 2000;
  localparam int         DRAIN_CYCLES   = 8;

  logic                clk;
  logic                rst;
  logic                byte_valid;
  logic                byte_stall;
  tgad_pkg::tgad_in_t  byte_item;
  logic                pix_valid;
  logic                pix_stall;
  tgad_pkg::tgad_out_t pix_item;

  tga_image_stream_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item (byte_item),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_item  (pix_item)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // decoder copy: state as after reset
  tgad_pkg::tgad_phase_t dec_phase = tgad_pkg::PH_HEADER;
  logic [8:0]  hdr_pos       = '0;
  logic [7:0]  id_len_q      = '0;
  logic [7:0]  kind_q        = '0;
  logic [15:0] width_q       = '0;
  logic [15:0] height_q      = '0;
  logic [7:0]  depth_q       = '0;
  logic [31:0] pix_remaining = '0;
  logic [23:0] pix_accum     = '0;
  logic [1:0]  pix_byte_idx  = '0;
  logic [7:0]  pkt_remaining = '0;
  logic        pkt_run       = 1'b0;

  tgad_pkg::tgad_out_t expected_pixels[$];
  int        mismatch_count  = 0;
  int        bytes_accepted  = 0;
  int        quiet_cycles    = 0;
  bit        send_idle_en    = 1'b1;
  bit        recv_idle_en    = 1'b1;
  bit        hold_request    = 1'b0;

  function automatic bit depth_ok(input logic [7:0] kind, input logic [7:0] dp);
    if (kind == tgad_pkg::KIND_RLE_TRUE)
      return dp == tgad_pkg::DEPTH_24 || dp == tgad_pkg::DEPTH_32;
    return dp == tgad_pkg::DEPTH_16 || dp == tgad_pkg::DEPTH_24 || dp == tgad_pkg::DEPTH_32;
  endfunction

  function automatic int bytes_per_pixel(input logic [7:0] dp);
    return (dp == tgad_pkg::DEPTH_16) ? 2 : (dp == tgad_pkg::DEPTH_24) ? 3 : 4;
  endfunction

  // work out what one accepted byte does to the decoder and what it emits
  task automatic predict_pixels(input tgad_pkg::tgad_in_t req);
    tgad_pkg::tgad_out_t res;
    logic [7:0]  b;
    logic [15:0] w16;
    logic [31:0] count;
    int          bpp;
    b   = req.data_byte;
    res = '0;
    if (req.file_start) begin
      dec_phase     = tgad_pkg::PH_HEADER;
      hdr_pos       = '0;
      pix_remaining = '0;
      pkt_remaining = '0;
      pkt_run       = 1'b0;
      pix_accum     = '0;
      pix_byte_idx  = '0;
    end
    if (dec_phase == tgad_pkg::PH_HEADER) begin
      case (hdr_pos)
        tgad_pkg::HDR_ID_LEN:    id_len_q = b;
        tgad_pkg::HDR_KIND:      kind_q = b;
        tgad_pkg::HDR_WIDTH_LO:  width_q[7:0] = b;
        tgad_pkg::HDR_WIDTH_HI:  width_q[15:8] = b;
        tgad_pkg::HDR_HEIGHT_LO: height_q[7:0] = b;
        tgad_pkg::HDR_HEIGHT_HI: height_q[15:8] = b;
        tgad_pkg::HDR_DEPTH:     depth_q = b;
        default: ;
      endcase
      // header and ID field consumed
      if (hdr_pos >= tgad_pkg::HDR_LEN && hdr_pos == tgad_pkg::HDR_LEN + id_len_q) begin
        if (!depth_ok(kind_q, depth_q)) begin
          res.image_done = 1'b1;
          res.status     = tgad_pkg::STATUS_BAD_DEPTH;
          expected_pixels.push_back(res);
          dec_phase = tgad_pkg::PH_IDLE;
        end else begin
          pix_remaining = 32'(width_q) * 32'(height_q);
          pix_accum     = '0;
          pix_byte_idx  = '0;
          pkt_remaining = '0;
          pkt_run       = 1'b0;
          dec_phase     = (pix_remaining == 0) ? tgad_pkg::PH_IDLE : tgad_pkg::PH_PIXELS;
        end
      end
      hdr_pos = hdr_pos + 9'd1;
    end else if (dec_phase == tgad_pkg::PH_PIXELS) begin
      if (kind_q == tgad_pkg::KIND_RLE_TRUE && pkt_remaining == 0) begin
        // packet header: raw below 128, run otherwise
        if (b < 8'd128) begin
          count   = 32'(b) + 32'd1;
          pkt_run = 1'b0;
        end else begin
          count   = 32'(b) - 32'd127;
          pkt_run = 1'b1;
        end
        if (count > pix_remaining)
          count = pix_remaining;
        pkt_remaining = count[7:0];
      end else begin
        bpp = bytes_per_pixel(depth_q);
        if (pix_byte_idx + 1 < bpp) begin
          pix_accum    = pix_accum | (24'(b) << (8 * pix_byte_idx));
          pix_byte_idx = pix_byte_idx + 2'd1;
        end else begin
          // last byte of the pixel
          if (bpp == 2) begin
            w16       = {b, pix_accum[7:0]};
            res.blue  = {w16[4:0], 3'b000};
            res.green = {w16[9:5], 3'b000};
            res.red   = {w16[14:10], 3'b000};
          end else if (bpp == 3) begin
            res.blue  = pix_accum[7:0];
            res.green = pix_accum[15:8];
            res.red   = b;
          end else begin
            res.blue  = pix_accum[7:0];
            res.green = pix_accum[15:8];
            res.red   = pix_accum[23:16];
            res.alpha = b;
          end
          pix_accum    = '0;
          pix_byte_idx = '0;
          if (kind_q == tgad_pkg::KIND_RLE_TRUE && pkt_run) begin
            count         = 32'(pkt_remaining);
            pkt_remaining = '0;
          end else begin
            count = 32'd1;
            if (kind_q == tgad_pkg::KIND_RLE_TRUE)
              pkt_remaining = pkt_remaining - 8'd1;
          end
          if (count > pix_remaining)
            count = pix_remaining;
          pix_remaining    = pix_remaining - count;
          res.has_alpha    = (depth_q == tgad_pkg::DEPTH_32);
          res.repeat_count = count[7:0];
          res.image_done   = (pix_remaining == 0);
          res.status       = tgad_pkg::STATUS_OK;
          if (pix_remaining == 0)
            dec_phase = tgad_pkg::PH_IDLE;
          expected_pixels.push_back(res);
        end
      end
    end
  endtask

  // offer one byte and wait until the decoder takes it
  task automatic send_byte(input logic [7:0] data, input logic start);
    tgad_pkg::tgad_in_t req;
    req.data_byte  = data;
    req.file_start = start;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= req;
    @(posedge clk);
    while (byte_stall)
      @(posedge clk);
    predict_pixels(req);
    bytes_accepted++;
  endtask

  // stop offering and let every predicted request come out
  task automatic wait_results_done();
    byte_valid <= 1'b0;
    do
      @(posedge clk);
    while (expected_pixels.size() != 0);
  endtask

  task automatic send_pixel(input logic [31:0] px, input int bpp);
    for (int i = 0; i < bpp; i++)
      send_byte(px[8 * i +: 8], 1'b0);
  endtask

  // 18 header bytes then the ID field; unused bytes are random
  task automatic send_header(input logic [7:0] id_len, input logic [7:0] kind,
                             input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] dp, input logic start);
    logic [7:0] b;
    for (int pos = 0; pos <= tgad_pkg::HDR_LEN; pos++) begin
      case (pos)
        tgad_pkg::HDR_ID_LEN:    b = id_len;
        tgad_pkg::HDR_KIND:      b = kind;
        tgad_pkg::HDR_WIDTH_LO:  b = w[7:0];
        tgad_pkg::HDR_WIDTH_HI:  b = w[15:8];
        tgad_pkg::HDR_HEIGHT_LO: b = h[7:0];
        tgad_pkg::HDR_HEIGHT_HI: b = h[15:8];
        tgad_pkg::HDR_DEPTH:     b = dp;
        default:                 b = 8'($urandom);
      endcase
      send_byte(b, start && pos == 0);
    end
    repeat (id_len) send_byte(8'($urandom), 1'b0);
  endtask

  // well-formed pixel data with random colors and packet sizes
  task automatic send_body(input logic [7:0] kind, input logic [7:0] dp,
                           input logic [15:0] w, input logic [15:0] h);
    int left;
    int cnt;
    int n;
    int bpp;
    bit run;
    left = int'(w) * int'(h);
    bpp  = bytes_per_pixel(dp);
    if (kind != tgad_pkg::KIND_RLE_TRUE) begin
      repeat (left) send_pixel($urandom, bpp);
    end else begin
      while (left > 0) begin
        run = $urandom_range(0, 1);
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        send_byte(run ? 8'(cnt + 127) : 8'(cnt - 1), 1'b0);
        n = (cnt > left) ? left : cnt;
        if (run)
          send_pixel($urandom, bpp);
        else
          repeat (n) send_pixel($urandom, bpp);
        left -= n;
      end
    end
  endtask

  task automatic send_file(input logic [7:0] id_len, input logic [7:0] kind,
                           input logic [7:0] dp, input logic [15:0] w,
                           input logic [15:0] h);
    send_header(id_len, kind, w, h, dp, 1'b1);
    if (depth_ok(kind, dp))
      send_body(kind, dp, w, h);
  endtask

  // mostly small complete files, some cut short, odd types and depths
  task automatic send_random_file();
    logic [7:0]  kind;
    logic [7:0]  dp;
    logic [7:0]  id_len;
    logic [15:0] w;
    logic [15:0] h;
    bit          cut;
    int          sel;
    sel  = $urandom_range(0, 9);
    kind = (sel < 4) ? tgad_pkg::KIND_RLE_TRUE : (sel < 7) ? KIND_RAW_TRUE :
           (sel == 7) ? KIND_RAW_GRAY : (sel == 8) ? KIND_NONE : 8'($urandom);
    sel  = $urandom_range(0, 9);
    dp   = (sel < 3) ? tgad_pkg::DEPTH_24 : (sel < 6) ? tgad_pkg::DEPTH_32 :
           (sel < 9) ? tgad_pkg::DEPTH_16 : 8'($urandom);
    id_len = ($urandom_range(0, 39) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    w   = 16'($urandom_range(1, 4));
    h   = 16'($urandom_range(1, 3));
    cut = ($urandom_range(0, 7) == 0);
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      w = '0;
    end else if (sel == 1) begin
      h = '0;
    end else if (sel < 4) begin
      // huge image, abandoned by the next file
      w   = 16'($urandom);
      h   = 16'($urandom);
      cut = 1'b1;
    end
    send_header(id_len, kind, w, h, dp, 1'b1);
    if (cut)
      repeat ($urandom_range(0, 24)) send_byte(8'($urandom), 1'b0);
    else if (depth_ok(kind, dp))
      send_body(kind, dp, w, h);
    // stray bytes after the image end are ignored
    if (!cut && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    if ($urandom_range(0, 5) == 0)
      wait_results_done();
  endtask

  // first file after reset without file_start
  task automatic test_headless_start();
    send_header(8'd0, KIND_RAW_TRUE, 16'd2, 16'd1, tgad_pkg::DEPTH_24, 1'b0);
    send_pixel(32'h000000, 3);
    send_pixel(32'hffffff, 3);
  endtask

  // uncompressed 16 and 32 bit pixels at the extremes
  task automatic test_raw_depths();
    send_header(8'd1, KIND_RAW_TRUE, 16'd2, 16'd1, tgad_pkg::DEPTH_16, 1'b1);
    send_pixel(32'h7fff, 2);
    send_pixel(32'h8000, 2);
    send_header(8'd0, KIND_RAW_GRAY, 16'd1, 16'd2, tgad_pkg::DEPTH_32, 1'b1);
    send_pixel(32'hffffffff, 4);
    send_pixel(32'h00000000, 4);
  endtask

  // raw and run packets, longest runs and packets past the image end
  task automatic test_rle_packets();
    send_header(8'd0, tgad_pkg::KIND_RLE_TRUE, 16'd2, 16'd2, tgad_pkg::DEPTH_24, 1'b1);
    send_byte(8'h01, 1'b0);
    send_pixel(32'h123456, 3);
    send_pixel(32'hfedcba, 3);
    send_byte(8'h80, 1'b0);
    send_pixel(32'h00ff00, 3);
    send_byte(8'hff, 1'b0);
    send_pixel(32'hff00ff, 3);
    send_header(8'd0, tgad_pkg::KIND_RLE_TRUE, 16'd128, 16'd1, tgad_pkg::DEPTH_32, 1'b1);
    send_byte(8'hff, 1'b0);
    send_pixel(32'h80402010, 4);
    send_header(8'd0, tgad_pkg::KIND_RLE_TRUE, 16'd3, 16'd1, tgad_pkg::DEPTH_32, 1'b1);
    send_byte(8'h7f, 1'b0);
    repeat (3) send_pixel($urandom, 4);
  endtask

  // unsupported depths report an error, then bytes are ignored
  task automatic test_bad_depth();
    send_header(8'd2, tgad_pkg::KIND_RLE_TRUE, 16'd1, 16'd1, tgad_pkg::DEPTH_16, 1'b1);
    repeat (3) send_byte(8'($urandom), 1'b0);
    send_header(8'd0, KIND_RAW_TRUE, 16'd1, 16'd1, 8'd8, 1'b1);
  endtask

  // zero width or height gives nothing
  task automatic test_empty_image();
    send_header(8'd0, KIND_RAW_TRUE, 16'd0, 16'd7, tgad_pkg::DEPTH_24, 1'b1);
    repeat (2) send_byte(8'($urandom), 1'b0);
    send_header(8'd0, tgad_pkg::KIND_RLE_TRUE, 16'd5, 16'd0, tgad_pkg::DEPTH_32, 1'b1);
  endtask

  // file_start mid header and mid pixel
  task automatic test_restart();
    send_byte(8'd0, 1'b1);
    repeat (7) send_byte(8'($urandom), 1'b0);
    send_header(8'd0, KIND_RAW_TRUE, 16'd2, 16'd1, tgad_pkg::DEPTH_24, 1'b1);
    send_pixel($urandom, 3);
    send_pixel($urandom, 2);
    send_file(8'd0, KIND_RAW_TRUE, tgad_pkg::DEPTH_16, 16'd1, 16'd1);
  endtask

  // longest ID field
  task automatic test_long_id();
    send_file(8'd255, KIND_RAW_TRUE, tgad_pkg::DEPTH_24, 16'd1, 16'd1);
  endtask

  task automatic test_random_files(input int count);
    int start;
    start = bytes_accepted;
    while (bytes_accepted - start < count)
      send_random_file();
  endtask

  // sender waits for the decoder to empty between two files
  task automatic test_drain_pause();
    send_file(8'd1, tgad_pkg::KIND_RLE_TRUE, tgad_pkg::DEPTH_24, 16'd3, 16'd2);
    wait_results_done();
    send_file(8'd0, KIND_RAW_TRUE, tgad_pkg::DEPTH_32, 16'd2, 16'd2);
  endtask

  // receiver holds off while a long file keeps coming
  task automatic test_receiver_hold();
    hold_request = 1'b1;
    send_file(8'd0, KIND_RAW_TRUE, tgad_pkg::DEPTH_32, 16'd4, 16'd4);
    wait_results_done();
  endtask

  // receiver stall pattern
  initial begin : receiver
    int n;
    pix_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        pix_stall <= 1'b1;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        hold_request = 1'b0;
        pix_stall <= 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 3) == 0) begin
        pix_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        pix_stall <= 1'b0;
      end else begin
        pix_stall <= 1'b0;
      end
    end
  end

  // compare each pixel request with the oldest prediction
  always @(posedge clk) begin
    tgad_pkg::tgad_out_t want;
    if (!rst && pix_valid && !pix_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected request: r=%h g=%h b=%h a=%h ha=%b rep=%0d done=%b st=%b",
                   pix_item.red, pix_item.green, pix_item.blue, pix_item.alpha,
                   pix_item.has_alpha, pix_item.repeat_count, pix_item.image_done,
                   pix_item.status);
      end else begin
        want = expected_pixels.pop_front();
        if (pix_item.red !== want.red || pix_item.green !== want.green ||
            pix_item.blue !== want.blue || pix_item.alpha !== want.alpha ||
            pix_item.has_alpha !== want.has_alpha ||
            pix_item.repeat_count !== want.repeat_count ||
            pix_item.image_done !== want.image_done || pix_item.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp r=%h g=%h b=%h a=%h ha=%b rep=%0d done=%b st=%b,",
                     want.red, want.green, want.blue, want.alpha, want.has_alpha,
                     want.repeat_count, want.image_done, want.status,
                     " got r=%h g=%h b=%h a=%h ha=%b rep=%0d done=%b st=%b",
                     pix_item.red, pix_item.green, pix_item.blue, pix_item.alpha,
                     pix_item.has_alpha, pix_item.repeat_count, pix_item.image_done,
                     pix_item.status);
        end
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (pix_valid && !pix_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("tga_image_stream_decoder_test failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_item  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_headless_start();
    test_raw_depths();
    test_rle_packets();
    test_bad_depth();
    test_empty_image();
    test_restart();
    test_long_id();
    test_random_files(30);
    test_drain_pause();
    test_receiver_hold();
    test_random_files(10);
    // last part runs without idling
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random_files(40);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tga_image_stream_decoder_test passed");
    else
      $display("tga_image_stream_decoder_test failed");
    $finish;
  end

endmodule

[tga_image_stream_decoder.f]
hw/rtl/tgad_pkg.sv
hw/rtl/tga_image_stream_decoder.sv
dv/tga_image_stream_decoder_test.sv
